### rtl/bfsa_pkg.sv
// Shared types and codes for the best-fit segment allocator.
// No dependencies; used by bfsa_ram and best_fit_segment_allocator.
`default_nettype none
package bfsa_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_REINIT  = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_TABLE_FUL = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_t;

  // one segment table entry: header offset, payload size, free flag
  typedef struct packed {
    logic [15:0] start;
    logic [15:0] size;
    logic        free;
  } seg_t;

  localparam logic [15:0] POOL_RESET = 16'd5000;

endpackage
`default_nettype wire

### rtl/bfsa_ram.sv
// Segment table storage: one write port, one read port, registered read data.
// Depends on bfsa_pkg for the entry type.
`default_nettype none
module bfsa_ram
  import bfsa_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [IW-1:0] waddr,
  input  wire seg_t          wdata,
  input  wire logic [IW-1:0] raddr,
  output seg_t               rdata
);

  seg_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/best_fit_segment_allocator.sv
// Best-fit segment allocator top level: control sequencer, result register, APB register.
// Depends on bfsa_pkg and bfsa_ram.
//
// The segment table lives in one synchronous RAM that is streamed one entry per
// cycle. An allocate scans the table, then moves up the entries behind the chosen
// segment and writes the new free entry when it splits; an exact fit ends at the
// matching entry. A release scans up to the matching entry, reads the free run
// behind it, then moves the remaining entries down one per cycle. Reinitialize
// and the unused op go straight to the result state. After reset the boot state
// writes entry zero before the first item is taken. pool_bytes is used only at
// reset and on reinitialize.
`default_nettype none
module best_fit_segment_allocator
  import bfsa_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int HEADER_BYTES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [15:0] in_request_bytes,
  input  wire logic [15:0] in_release_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [15:0]      out_payload_address,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [15:0] HDR = 16'(HEADER_BYTES);
  localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

  typedef enum logic [9:0] {
    S_BOOT   = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_ASCAN  = 10'b0000000100,
    S_ASHIFT = 10'b0000001000,
    S_ANEW   = 10'b0000010000,
    S_AFIN   = 10'b0000100000,
    S_RSCAN  = 10'b0001000000,
    S_RMERGE = 10'b0010000000,
    S_RSHIFT = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [IW-1:0] best_r, best_nxt;
  logic          found_r, found_nxt;
  logic [15:0]   best_sz_r, best_sz_nxt;
  logic [15:0]   best_st_r, best_st_nxt;
  logic [15:0]   new_st_r, new_st_nxt;
  logic [15:0]   new_sz_r, new_sz_nxt;
  logic [15:0]   req_r, req_nxt;
  logic [15:0]   rel_r, rel_nxt;
  logic [15:0]   acc_r, acc_nxt;
  status_t       res_st_r, res_st_nxt;
  logic [15:0]   res_addr_r, res_addr_nxt;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [15:0]   out_addr_r;
  logic [15:0]   pool_r;
  logic          rel_path_r;

  logic          rd_vld_r;
  logic [IW-1:0] rd_idx_r;
  state_t        rd_st_r;

  logic          issue;
  logic [IW-1:0] raddr;
  logic          we;
  logic [IW-1:0] waddr;
  seg_t          wdata;
  seg_t          e;

  logic          accept, cons, last, load_out;
  logic [CW-1:0] ci;

  bfsa_ram #(.DEPTH(MAX_SEGMENTS), .IW(IW)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(e)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // read data belongs to the phase that issued it; stale reads are dropped
  assign cons     = rd_vld_r && (rd_st_r == state_r);
  assign ci       = CW'(rd_idx_r);
  assign last     = (ci == count_r - CW'(1));
  assign load_out = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    logic          f;
    logic [IW-1:0] b;
    logic [15:0]   bsz, bst;
    logic [16:0]   need;
    state_nxt    = state_r;
    ptr_nxt      = ptr_r;
    count_nxt    = count_r;
    n_nxt        = n_r;
    best_nxt     = best_r;
    found_nxt    = found_r;
    best_sz_nxt  = best_sz_r;
    best_st_nxt  = best_st_r;
    new_st_nxt   = new_st_r;
    new_sz_nxt   = new_sz_r;
    req_nxt      = req_r;
    rel_nxt      = rel_r;
    acc_nxt      = acc_r;
    res_st_nxt   = res_st_r;
    res_addr_nxt = res_addr_r;
    issue        = 1'b0;
    raddr        = ptr_r[IW-1:0];
    we           = 1'b0;
    waddr        = '0;
    wdata        = '0;
    f            = found_r;
    b            = best_r;
    bsz          = best_sz_r;
    bst          = best_st_r;
    need         = {1'b0, HDR} + {1'b0, req_r};
    case (state_r)
      S_BOOT: begin
        we        = 1'b1;
        waddr     = '0;
        wdata     = '{start: 16'd0, size: (pool_r > HDR) ? pool_r - HDR : 16'd0, free: 1'b1};
        count_nxt = CW'(1);
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          req_nxt      = in_request_bytes;
          rel_nxt      = in_release_address;
          ptr_nxt      = '0;
          found_nxt    = 1'b0;
          res_st_nxt   = ST_OK;
          res_addr_nxt = '0;
          case (op_t'(in_op))
            OP_ALLOC:   state_nxt = S_ASCAN;
            OP_RELEASE: state_nxt = S_RSCAN;
            OP_REINIT: begin
              we        = 1'b1;
              waddr     = '0;
              wdata     = '{start: 16'd0, size: (pool_r > HDR) ? pool_r - HDR : 16'd0,
                            free: 1'b1};
              count_nxt = CW'(1);
              state_nxt = S_OUT;
            end
            default:    state_nxt = S_OUT;
          endcase
        end
      end
      S_ASCAN: begin
        issue = (ptr_r < count_r);
        if (issue) ptr_nxt = ptr_r + CW'(1);
        if (cons) begin
          if (e.free && e.size == req_r) begin
            we           = 1'b1;
            waddr        = rd_idx_r;
            wdata        = '{start: e.start, size: e.size, free: 1'b0};
            res_addr_nxt = e.start + HDR;
            state_nxt    = S_OUT;
          end else begin
            if (e.free && e.size > req_r && (!found_r || e.size < best_sz_r)) begin
              f   = 1'b1;
              b   = rd_idx_r;
              bsz = e.size;
              bst = e.start;
            end
            found_nxt   = f;
            best_nxt    = b;
            best_sz_nxt = bsz;
            best_st_nxt = bst;
            if (last) begin
              new_st_nxt = 16'({2'b00, bst} + {2'b00, HDR} + {2'b00, req_r});
              new_sz_nxt = bsz - HDR - req_r;
              if (!f) begin
                res_st_nxt = ST_NO_FIT;
                state_nxt  = S_OUT;
              end else if ({1'b0, bsz} > need) begin
                if (count_r >= MAXC) begin
                  res_st_nxt = ST_TABLE_FUL;
                  state_nxt  = S_OUT;
                end else begin
                  best_sz_nxt = req_r;
                  ptr_nxt     = count_r - CW'(1);
                  state_nxt   = (count_r - CW'(1) == CW'(b)) ? S_ANEW : S_ASHIFT;
                end
              end else begin
                state_nxt = S_AFIN;
              end
            end
          end
        end
      end
      S_ASHIFT: begin
        // move entries best+1 .. count-1 up by one, top first
        issue = (ptr_r > CW'(best_r));
        if (issue) ptr_nxt = ptr_r - CW'(1);
        if (cons) begin
          we    = 1'b1;
          waddr = IW'(ci + CW'(1));
          wdata = e;
          if (ci == CW'(best_r) + CW'(1)) state_nxt = S_ANEW;
        end
      end
      S_ANEW: begin
        we        = 1'b1;
        waddr     = IW'(CW'(best_r) + CW'(1));
        wdata     = '{start: new_st_r, size: new_sz_r, free: 1'b1};
        count_nxt = count_r + CW'(1);
        state_nxt = S_AFIN;
      end
      S_AFIN: begin
        we           = 1'b1;
        waddr        = best_r;
        wdata        = '{start: best_st_r, size: best_sz_r, free: 1'b0};
        res_addr_nxt = best_st_r + HDR;
        state_nxt    = S_OUT;
      end
      S_RSCAN: begin
        issue = (ptr_r < count_r);
        if (issue) ptr_nxt = ptr_r + CW'(1);
        if (cons) begin
          if (!e.free && ({1'b0, e.start} + {1'b0, HDR}) == {1'b0, rel_r}) begin
            best_nxt    = rd_idx_r;
            best_st_nxt = e.start;
            acc_nxt     = e.size;
            n_nxt       = '0;
            ptr_nxt     = ci + CW'(1);
            state_nxt   = last ? S_AFIN : S_RMERGE;
          end else if (last) begin
            res_st_nxt = ST_NOT_ALLOC;
            state_nxt  = S_OUT;
          end
        end
      end
      S_RMERGE: begin
        // absorb the run of free entries behind the released one
        issue = (ptr_r < count_r);
        if (issue) ptr_nxt = ptr_r + CW'(1);
        if (cons) begin
          if (e.free) begin
            acc_nxt = acc_r + HDR + e.size;
            n_nxt   = n_r + CW'(1);
            if (last) state_nxt = S_AFIN;
          end else if (n_r == '0) begin
            state_nxt = S_AFIN;
          end else begin
            ptr_nxt   = ci;
            state_nxt = S_RSHIFT;
          end
        end
      end
      S_RSHIFT: begin
        issue = (ptr_r < count_r);
        if (issue) ptr_nxt = ptr_r + CW'(1);
        if (cons) begin
          we    = 1'b1;
          waddr = IW'(ci - n_r);
          wdata = e;
          if (last) state_nxt = S_AFIN;
        end
      end
      S_OUT: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_BOOT;
    endcase
    // the release path finishes through S_AFIN with a free, merged entry
    if (state_r == S_AFIN && rel_path_r) begin
      wdata        = '{start: best_st_r, size: acc_r, free: 1'b1};
      res_addr_nxt = '0;
      count_nxt    = count_r - n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BOOT;
      count_r     <= CW'(1);
      rd_vld_r    <= 1'b0;
      rd_st_r     <= S_BOOT;
      out_valid_r <= 1'b0;
      pool_r      <= POOL_RESET;
      rel_path_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rd_vld_r <= issue;
      rd_st_r  <= state_r;
      if (accept) rel_path_r <= (op_t'(in_op) == OP_RELEASE);
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
        pool_r <= cfg_pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    n_r        <= n_nxt;
    best_r     <= best_nxt;
    found_r    <= found_nxt;
    best_sz_r  <= best_sz_nxt;
    best_st_r  <= best_st_nxt;
    new_st_r   <= new_st_nxt;
    new_sz_r   <= new_sz_nxt;
    req_r      <= req_nxt;
    rel_r      <= rel_nxt;
    acc_r      <= acc_nxt;
    res_st_r   <= res_st_nxt;
    res_addr_r <= res_addr_nxt;
    rd_idx_r   <= raddr;
    if (load_out) begin
      out_status_r <= res_st_r;
      out_addr_r   <= res_addr_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_payload_address = out_addr_r;
  assign cfg_pready          = 1'b1;
  assign cfg_prdata          = cfg_paddr[2] ? 32'd0 : {16'd0, pool_r};

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_BOOT) |-> (count_r >= CW'(1) && count_r <= MAXC))
    else $error("segment count out of range");

  a_reinit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_REINIT) |=> (count_r == CW'(1)))
    else $error("reinitialize did not reset the segment count");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the result state");

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking bench for best_fit_segment_allocator: random alloc/release/reinit/none items
// checked against a behavioral segment-table allocator. Depends on bfsa_pkg and the RTL.
`default_nettype none

class alloc_scoreboard;
  localparam int NSEG = 64;
  localparam int HDR  = 16;
  logic [15:0] pool_sz;
  logic [15:0] seg_start [NSEG];
  logic [15:0] seg_size  [NSEG];
  bit          seg_free  [NSEG];
  int          seg_cnt;
  logic [1:0]  want_status [$];
  logic [15:0] want_addr   [$];
  int          errors;

  function new();
    pool_sz = bfsa_pkg::POOL_RESET;
    errors = 0;
    rebuild();
  endfunction

  function void rebuild();
    for (int k = 0; k < NSEG; k++) begin
      seg_start[k] = 0; seg_size[k] = 0; seg_free[k] = 0;
    end
    seg_size[0] = (pool_sz > HDR) ? pool_sz - HDR : 16'd0;
    seg_free[0] = 1;
    seg_cnt = 1;
  endfunction

  // picks a random payload address currently allocated, for aiming releases; returns 0 if none
  function int pick_live(output logic [15:0] a);
    int n;
    int ix [$];
    n = 0;
    for (int k = 0; k < seg_cnt; k++) if (!seg_free[k]) ix.push_back(k);
    if (ix.size() == 0) return 0;
    n = ix[$urandom_range(ix.size() - 1)];
    a = seg_start[n] + HDR;
    return 1;
  endfunction

  function void note_item(bfsa_pkg::op_t op, logic [15:0] req, logic [15:0] rel);
    logic [1:0] st;
    logic [15:0] ad;
    int best, bsz, k;
    bit found, done;
    st = bfsa_pkg::ST_OK; ad = 0; found = 0; done = 0; best = 0; bsz = 0;
    case (op)
      bfsa_pkg::OP_ALLOC: begin
        for (k = 0; k < seg_cnt && !done; k++) begin
          if (seg_free[k]) begin
            if (seg_size[k] == req) begin
              seg_free[k] = 0; ad = seg_start[k] + HDR; done = 1;
            end else if (seg_size[k] > req && (!found || seg_size[k] < bsz)) begin
              found = 1; best = k; bsz = seg_size[k];
            end
          end
        end
        if (!done) begin
          if (!found) st = bfsa_pkg::ST_NO_FIT;
          else if (bsz > HDR + int'(req) && seg_cnt >= NSEG) st = bfsa_pkg::ST_TABLE_FUL;
          else begin
            if (bsz > HDR + int'(req)) begin
              for (k = seg_cnt; k > best + 1; k--) begin
                seg_start[k] = seg_start[k-1]; seg_size[k] = seg_size[k-1];
                seg_free[k] = seg_free[k-1];
              end
              seg_start[best+1] = seg_start[best] + HDR + req;
              seg_size[best+1] = bsz - HDR - req;
              seg_free[best+1] = 1;
              seg_cnt++;
              seg_size[best] = req;
            end
            seg_free[best] = 0;
            ad = seg_start[best] + HDR;
          end
        end
      end
      bfsa_pkg::OP_RELEASE: begin
        for (k = 0; k < seg_cnt; k++)
          if (!seg_free[k] && int'(seg_start[k]) + HDR == int'(rel)) break;
        if (k >= seg_cnt) st = bfsa_pkg::ST_NOT_ALLOC;
        else begin
          seg_free[k] = 1;
          while (k + 1 < seg_cnt && seg_free[k+1]) begin
            seg_size[k] = seg_size[k] + HDR + seg_size[k+1];
            for (int m = k + 1; m + 1 < seg_cnt; m++) begin
              seg_start[m] = seg_start[m+1]; seg_size[m] = seg_size[m+1];
              seg_free[m] = seg_free[m+1];
            end
            seg_cnt--;
          end
        end
      end
      bfsa_pkg::OP_REINIT: rebuild();
      default: ;
    endcase
    want_status.push_back(st);
    want_addr.push_back(ad);
  endfunction

  function void check_result(logic [1:0] st, logic [15:0] ad);
    if (want_status.size() == 0) begin
      report("result with nothing pending", 0, st);
      return;
    end
    if (st !== want_status[0]) report("status", want_status[0], st);
    if (ad !== want_addr[0]) report("payload_address", want_addr[0], ad);
    void'(want_status.pop_front());
    void'(want_addr.pop_front());
  endfunction

  function void report(string what, int exp_v, int got_v);
    errors++;
    $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bfsa_pkg::*;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_stall = 0;
  logic [1:0] in_op = OP_NONE;
  logic [15:0] in_request_bytes = 0, in_release_address = 0;
  logic in_stall, out_valid;
  logic [1:0] out_status;
  logic [15:0] out_payload_address;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0] cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  localparam logic [2:0] REG_POOL_BYTES = 3'd0;
  localparam int CYCLE_LIMIT = 2000000;

  alloc_scoreboard sb = new();
  int cycles = 0;
  int stall_left = 0;

  best_fit_segment_allocator u_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(3);
    return $urandom_range(40, 120);
  endfunction

  // result side: check on accept, random stall runs
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_status, out_payload_address);
    if (stall_left > 0) begin
      out_stall  <= 1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(3) == 0) begin
      out_stall  <= 1;
      stall_left <= gap_len();
    end else begin
      out_stall <= 0;
    end
  end

  task automatic send_item(op_t op, logic [15:0] req, logic [15:0] rel);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1; in_op <= op; in_request_bytes <= req; in_release_address <= rel;
    do @(posedge clk); while (in_stall);
    sb.note_item(op, req, rel);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.want_status.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_pool(logic [15:0] v);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= REG_POOL_BYTES; cfg_pwdata <= {16'd0, v};
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    sb.pool_sz = v;
    @(posedge clk);
  endtask

  task automatic rand_item(bit tiny);
    logic [15:0] a;
    int r;
    r = $urandom_range(99);
    if (r < 50) begin
      if (tiny) send_item(OP_ALLOC, $urandom_range(40), 0);
      else if ($urandom_range(9) == 0) send_item(OP_ALLOC, $urandom(), 0);
      else send_item(OP_ALLOC, $urandom_range(600), 0);
    end else if (r < 88) begin
      if (sb.pick_live(a) && $urandom_range(9) != 0) send_item(OP_RELEASE, $urandom(), a);
      else send_item(OP_RELEASE, $urandom(), $urandom());
    end else if (r < 92) send_item(OP_REINIT, $urandom(), $urandom());
    else if (r < 94) send_item(OP_NONE, $urandom(), $urandom());
    else send_item(OP_ALLOC, 0, $urandom());
  endtask

  initial begin
    logic [15:0] pools [5];
    pools = '{16'd64, 16'd65535, 16'd10, 16'd1200, 16'd5000};
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, every op, split vs. whole grant, no-fit, bad release
    send_item(OP_ALLOC, 16'd0, 0);
    send_item(OP_ALLOC, 16'hFFFF, 0);
    send_item(OP_ALLOC, 16'd100, 16'hFFFF);
    send_item(OP_ALLOC, 16'd100, 0);
    send_item(OP_RELEASE, 0, 16'd16);
    send_item(OP_RELEASE, 0, 16'd16);
    send_item(OP_RELEASE, 0, 16'hFFFF);
    send_item(OP_ALLOC, 16'd90, 0);
    send_item(OP_ALLOC, 16'd4000, 0);
    send_item(OP_NONE, 16'hFFFF, 16'hFFFF);
    send_item(OP_RELEASE, 0, 16'd132);
    send_item(OP_RELEASE, 0, 16'd16);
    send_item(OP_REINIT, 16'hFFFF, 16'hFFFF);
    // fill the table with tiny grants to reach the full-table case
    for (int i = 0; i < 70; i++) send_item(OP_ALLOC, 16'd1, 0);
    send_item(OP_REINIT, 0, 0);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_pool(pools[p]);
      send_item(OP_REINIT, 0, 0);
      send_item(OP_ALLOC, 16'd0, 0);
      for (int i = 0; i < 260; i++) rand_item(p == 0 || p == 2);
      drain();
    end

    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

`default_nettype wire
